>>> hw/rtl/jet_pkg.sv
// Shared types and constants of the Julia escape-time block.
// Holds the sequencer states, control bundle, register indexes and config layout.
// No dependencies.
`default_nettype none

package jet_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int C_W        = 14;
  localparam int ORG_W      = 16;
  localparam int STEP_W     = 15;
  localparam int LIM_W      = 6;
  localparam int COUNT_W    = 6;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd30;

  localparam logic [CFG_ADDR_W-1:0] REG_C_REAL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_C_IMAG    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIM  = 3'd5;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INIT_X = 8'b0000_0010,
    S_INIT_Y = 8'b0000_0100,
    S_SQ_RE  = 8'b0000_1000,
    S_SQ_IM  = 8'b0001_0000,
    S_CROSS  = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    MUL_COL_STEP = 3'd0,
    MUL_ROW_STEP = 3'd1,
    MUL_RE_RE    = 3'd2,
    MUL_IM_IM    = 3'd3,
    MUL_RE_IM    = 3'd4
  } mul_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     capture;
    logic     load_re;
    logic     load_im;
    logic     save_sq;
    logic     save_diff;
    logic     update_z;
  } ctrl_t;

  typedef struct packed {
    logic [C_W-1:0]    c_real;
    logic [C_W-1:0]    c_imag;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [STEP_W-1:0] pixel_step;
    logic [LIM_W-1:0]  iteration_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/jet_cfg_regs.sv
// Configuration register file of the Julia escape-time block.
// Depends on jet_pkg for register indexes and the cfg_t layout.
`default_nettype none

module jet_cfg_regs import jet_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_C_REAL:   cfg_d.c_real          = cfg_data_i[C_W-1:0];
        REG_C_IMAG:   cfg_d.c_imag          = cfg_data_i[C_W-1:0];
        REG_ORIGIN_X: cfg_d.origin_x        = cfg_data_i[ORG_W-1:0];
        REG_ORIGIN_Y: cfg_d.origin_y        = cfg_data_i[ORG_W-1:0];
        REG_STEP:     cfg_d.pixel_step      = cfg_data_i[STEP_W-1:0];
        REG_ITER_LIM: cfg_d.iteration_limit = cfg_data_i[LIM_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {{(2 * C_W + 2 * ORG_W + STEP_W){1'b0}}, LIMIT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/jet_mult.sv
// Shared signed multiplier with a registered product.
// Used for the pixel offsets and all three products of each step; no dependencies.
`default_nettype none

module jet_mult #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> hw/rtl/jet_datapath.sv
// Fixed-point datapath: z registers, operand select, saturation and escape test.
// Depends on jet_pkg and instantiates jet_mult.
`default_nettype none

module jet_datapath import jet_pkg::*; #(
  parameter int FRAC_BITS  = 12,
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  ctrl_t                 ctrl_i,
  input  cfg_t                  cfg_i,
  input  logic [COORD_BITS-1:0] pixel_col_i,
  input  logic [COORD_BITS-1:0] pixel_row_i,
  output logic                  escape_o
);

  localparam int VAL_W  = FRAC_BITS + 4;
  localparam int OPD_W  = ((COORD_BITS > STEP_W) ? COORD_BITS : STEP_W) + 1;
  localparam int MUL_W  = (VAL_W > OPD_W) ? VAL_W : OPD_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] VAL_MAX = ACC_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] VAL_MIN = -VAL_MAX - ACC_W'(1);
  localparam logic [PROD_W:0] ESC_LIM = {{PROD_W{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] r;
    r = x;
    if (x > VAL_MAX) r = VAL_MAX;
    if (x < VAL_MIN) r = VAL_MIN;
    return r[VAL_W-1:0];
  endfunction

  logic [COORD_BITS-1:0]   col_q, row_q;
  logic signed [VAL_W-1:0] re_q, re_d, im_q, im_d;
  logic signed [PROD_W-1:0] rr_q;
  logic signed [ACC_W-1:0]  diff_q;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  col_s, row_s, step_s;
  logic signed [ACC_W-1:0]  prod_x, diff_d, nre_acc, nim_acc;
  logic [PROD_W:0]          mag_sq;

  assign col_s  = $signed(MUL_W'(col_q));
  assign row_s  = $signed(MUL_W'(row_q));
  assign step_s = $signed(MUL_W'(cfg_i.pixel_step));

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_COL_STEP: begin op_a = col_s;          op_b = step_s;         end
      MUL_ROW_STEP: begin op_a = row_s;          op_b = step_s;         end
      MUL_RE_RE:    begin op_a = MUL_W'(re_q);   op_b = MUL_W'(re_q);   end
      MUL_IM_IM:    begin op_a = MUL_W'(im_q);   op_b = MUL_W'(im_q);   end
      MUL_RE_IM:    begin op_a = MUL_W'(re_q);   op_b = MUL_W'(im_q);   end
      default:      begin op_a = '0;             op_b = '0;             end
    endcase
  end

  jet_mult #(.W(MUL_W)) u_mult (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  assign prod_x  = ACC_W'(prod);
  assign mag_sq  = {1'b0, rr_q} + {1'b0, prod};
  assign escape_o = (mag_sq >= ESC_LIM);
  assign diff_d  = ACC_W'(rr_q) - prod_x;
  assign nre_acc = (diff_q >>> FRAC_BITS) + ACC_W'($signed(cfg_i.c_real));
  assign nim_acc = (prod_x >>> (FRAC_BITS - 1)) + ACC_W'($signed(cfg_i.c_imag));

  always_comb begin
    re_d = re_q;
    im_d = im_q;
    if (ctrl_i.load_re) re_d = sat(ACC_W'($signed(cfg_i.origin_x)) + prod_x);
    if (ctrl_i.load_im) im_d = sat(ACC_W'($signed(cfg_i.origin_y)) + prod_x);
    if (ctrl_i.update_z) begin
      re_d = sat(nre_acc);
      im_d = sat(nim_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    re_q <= re_d;
    im_q <= im_d;
    if (ctrl_i.save_sq)   rr_q   <= prod;
    if (ctrl_i.save_diff) diff_q <= diff_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/jet_seq.sv
// Sequencer: steps the shared multiplier, counts iterations, holds the result.
// Depends on jet_pkg for states and the control bundle.
`default_nettype none

module jet_seq import jet_pkg::*; #(
  parameter int ITER_MAX = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] escape_count_o,
  input  logic [LIM_W-1:0]   limit_i,
  input  logic               escape_i,
  output ctrl_t              ctrl_o
);

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] iter_q, iter_d;
  logic [COUNT_W-1:0] res_q, res_d;
  logic [COUNT_W-1:0] out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [LIM_W-1:0]   limit_eff;
  logic               accept, last;

  assign limit_eff = (32'(limit_i) > ITER_MAX) ? LIM_W'(ITER_MAX) : limit_i;
  assign last      = (({1'b0, iter_q} + 7'd1) >= {1'b0, limit_eff});
  assign accept    = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_q;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl_o      = '0;
    ctrl_o.mul_sel = MUL_COL_STEP;
    case (state_q)
      S_IDLE: begin
        ctrl_o.capture = accept;
        iter_d = '0;
        if (accept) state_d = S_INIT_X;
      end
      S_INIT_X: begin
        state_d = S_INIT_Y;
      end
      S_INIT_Y: begin
        ctrl_o.mul_sel = MUL_ROW_STEP;
        ctrl_o.load_re = 1'b1;
        state_d = S_SQ_RE;
      end
      S_SQ_RE: begin
        ctrl_o.mul_sel = MUL_RE_RE;
        ctrl_o.load_im = (iter_q == '0);
        state_d = S_SQ_IM;
      end
      S_SQ_IM: begin
        ctrl_o.mul_sel = MUL_IM_IM;
        ctrl_o.save_sq = 1'b1;
        state_d = S_CROSS;
      end
      S_CROSS: begin
        ctrl_o.mul_sel   = MUL_RE_IM;
        ctrl_o.save_diff = 1'b1;
        if (iter_q != '0 && escape_i) begin
          res_d   = iter_q;
          state_d = S_DONE;
        end else if (last) begin
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        ctrl_o.mul_sel  = MUL_RE_IM;
        ctrl_o.update_z = 1'b1;
        iter_d  = iter_q + COUNT_W'(1);
        state_d = S_SQ_RE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/julia_escape_time.sv
// Julia-set escape-time unit. One pixel (column, row) goes in and one escape count comes out.
// An item runs from its input transfer to the next possible one in these steps: S_INIT_X and
// S_INIT_Y form the start point, S_SQ_RE, S_SQ_IM and S_CROSS square it and test it, then
// each step runs S_UPDATE and those three again, as the single shared multiplier forms re*re,
// im*im and re*im one after another; S_DONE loads the output register and the sequencer returns
// to idle. Steps run before escape or the limit: 0 when iteration_limit is below 2, at most
// iteration_limit - 1. The input is stalled while a pixel is in work; a finished count waits in
// an output register, and while it still holds a stalled count the sequencer waits too.
// Top level; depends on jet_pkg, jet_cfg_regs, jet_seq and jet_datapath.
`default_nettype none

module julia_escape_time import jet_pkg::*; #(
  parameter int FRAC_BITS  = 12,
  parameter int COORD_BITS = 10,
  parameter int ITER_MAX   = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pixel_col_i,
  input  logic [COORD_BITS-1:0] pixel_row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COUNT_W-1:0]    escape_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  escape;

  jet_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  jet_seq #(.ITER_MAX(ITER_MAX)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o),
    .limit_i        (cfg.iteration_limit),
    .escape_i       (escape),
    .ctrl_o         (ctrl)
  );

  jet_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .escape_o    (escape)
  );

endmodule

`default_nettype wire

>>> hw/rtl/jet_checker.sv
// Port-level checks of the Julia escape-time block, bound to the top level.
// Depends on jet_pkg for port widths.
`default_nettype none

module jet_checker import jet_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [COORD_BITS-1:0] pixel_col_i,
  input logic [COORD_BITS-1:0] pixel_row_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COUNT_W-1:0]    escape_count_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> ($stable(pixel_col_i) && $stable(pixel_row_i)))
    else $error("stalled pixel changed");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no pixel in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(escape_count_o)))
    else $error("stalled result dropped or changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (escape_count_o != {COUNT_W{1'b1}}))
    else $error("escape count beyond the iteration bound");

endmodule

bind julia_escape_time jet_checker #(.COORD_BITS(COORD_BITS)) u_jet_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .pixel_col_i    (pixel_col_i),
  .pixel_row_i    (pixel_row_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .escape_count_o (escape_count_o)
);

`default_nettype wire
